/* rtl/tun_pkg.sv */
// ----------------------------------------------------------------------------
// tun_pkg - shared types and constants of the triangle unit normal pipeline
// Widths of the edge, product and cross product stages follow from the coordinate width.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_BITS = 32;
  // coordinate width, held to 16..48
  localparam int CW   = (COORD_BITS < 16) ? 16 : (COORD_BITS > 48) ? 48 : COORD_BITS;
  localparam int EW   = CW + 1;          // edge vector component
  localparam int PW   = 2 * EW;          // one partial product
  localparam int NW   = PW + 1;          // cross product component
  localparam int LW   = $clog2(NW + 1);  // bit length of a magnitude
  localparam int MW   = 31;              // normalized magnitude
  localparam int SQW  = 2 * MW;          // square of one magnitude
  localparam int SUMW = 64;              // sum of squares
  localparam int RW   = SUMW / 2;        // square root
  localparam int REMW = RW + 2;          // square root remainder
  localparam int FRAC = 30;              // fraction bits of Q2.30
  localparam int QW   = 31;              // quotient magnitude
  localparam int NUMW = MW + FRAC + 1;   // dividend
  localparam int OW   = 32;              // output component

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [OW-1:0] normal_x;
    logic signed [OW-1:0] normal_y;
    logic signed [OW-1:0] normal_z;
    logic                 degenerate;
  } nrm_out_t;

  // cross product as sign and magnitude
  typedef struct packed {
    logic [2:0][NW-1:0] mag;
    logic [2:0]         neg;
  } crs_t;

  // data that rides along the root and divide stages
  typedef struct packed {
    logic [2:0][MW-1:0] m;
    logic [2:0]         neg;
    logic               deg;
  } side_t;

  typedef struct packed {
    logic [SUMW-1:0] sum;
    side_t           side;
  } sos_t;

  typedef struct packed {
    logic [RW-1:0] root;
    side_t         side;
  } root_t;

  typedef struct packed {
    logic [2:0][QW-1:0] q;
    logic [2:0]         neg;
    logic               deg;
  } quo_t;

  // keep the low CW bits as a signed value; wider coordinates zero extend
  function automatic logic signed [CW-1:0] coord_f(logic signed [31:0] raw);
    logic [CW+31:0] ext;
    ext = {{CW{1'b0}}, raw};
    return $signed(ext[CW-1:0]);
  endfunction

endpackage

/* rtl/tun_cross.sv */
// ----------------------------------------------------------------------------
// tun_cross - edge vectors, partial products and cross product
// Three register stages; the last one gives sign and magnitude.
// ----------------------------------------------------------------------------
module tun_cross import tun_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  logic    vld_i,
  input  tri_in_t tri_i,
  output logic    vld_o,
  output crs_t    crs_o
);

  logic signed [EW-1:0] e_d [6];
  logic signed [EW-1:0] e_q [6];
  logic signed [PW-1:0] p_d [6];
  logic signed [PW-1:0] p_q [6];
  logic signed [NW-1:0] n   [3];
  crs_t                 crs_d, crs_q;
  logic [2:0]           vld_q;

  // edges: u = a - b, v = a - c
  always_comb begin
    e_d[0] = EW'(coord_f(tri_i.a_x)) - EW'(coord_f(tri_i.b_x));
    e_d[1] = EW'(coord_f(tri_i.a_y)) - EW'(coord_f(tri_i.b_y));
    e_d[2] = EW'(coord_f(tri_i.a_z)) - EW'(coord_f(tri_i.b_z));
    e_d[3] = EW'(coord_f(tri_i.a_x)) - EW'(coord_f(tri_i.c_x));
    e_d[4] = EW'(coord_f(tri_i.a_y)) - EW'(coord_f(tri_i.c_y));
    e_d[5] = EW'(coord_f(tri_i.a_z)) - EW'(coord_f(tri_i.c_z));
  end

  always_comb begin
    p_d[0] = e_q[1] * e_q[5];
    p_d[1] = e_q[2] * e_q[4];
    p_d[2] = e_q[2] * e_q[3];
    p_d[3] = e_q[0] * e_q[5];
    p_d[4] = e_q[0] * e_q[4];
    p_d[5] = e_q[1] * e_q[3];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n[i]          = NW'(p_q[2*i]) - NW'(p_q[2*i+1]);
      crs_d.neg[i]  = n[i][NW-1];
      crs_d.mag[i]  = n[i][NW-1] ? NW'(-n[i]) : NW'(n[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e_q   <= e_d;
      p_q   <= p_d;
      crs_q <= crs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  assign vld_o = vld_q[2];
  assign crs_o = crs_q;

endmodule

/* rtl/tun_norm.sv */
// ----------------------------------------------------------------------------
// tun_norm - scale the cross product into 31 bits and sum the squares
// Four register stages: bit length, shift, squares, sum.
// ----------------------------------------------------------------------------
module tun_norm import tun_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic vld_i,
  input  crs_t crs_i,
  output logic vld_o,
  output sos_t sos_o
);

  localparam logic [LW-1:0] MW_L = LW'(MW);

  logic [NW-1:0]  orv;
  logic [LW-1:0]  s_d, s_q;
  crs_t           crs_q;
  logic [NW-1:0]  shl [3];
  logic [NW-1:0]  shr [3];
  side_t          side_d, side_q, side2_q;
  logic [SQW-1:0] sq_d [3];
  logic [SQW-1:0] sq_q [3];
  sos_t           sos_d, sos_q;
  logic [3:0]     vld_q;

  // the OR of the magnitudes has the bit length of the largest
  always_comb begin
    orv = crs_i.mag[0] | crs_i.mag[1] | crs_i.mag[2];
    s_d = '0;
    for (int b = 0; b < NW; b++) begin
      if (orv[b]) s_d = LW'(b + 1);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shl[i]         = crs_q.mag[i] << (MW_L - s_q);
      shr[i]         = crs_q.mag[i] >> (s_q - MW_L);
      side_d.m[i]    = (s_q < MW_L) ? shl[i][MW-1:0] : shr[i][MW-1:0];
    end
    side_d.neg = crs_q.neg;
    side_d.deg = (s_q == '0);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = SQW'(side_q.m[i]) * SQW'(side_q.m[i]);
    end
    sos_d.sum  = SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);
    sos_d.side = side2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s_q     <= s_d;
      crs_q   <= crs_i;
      side_q  <= side_d;
      sq_q    <= sq_d;
      side2_q <= side_q;
      sos_q   <= sos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  assign vld_o = vld_q[3];
  assign sos_o = sos_q;

endmodule

/* rtl/tun_sqrt.sv */
// ----------------------------------------------------------------------------
// tun_sqrt - pipelined integer square root
// One root bit per register stage, RW stages.
// ----------------------------------------------------------------------------
module tun_sqrt import tun_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  vld_i,
  input  sos_t  sos_i,
  output logic  vld_o,
  output root_t root_o
);

  logic [SUMW-1:0] rest_q [RW];
  logic [REMW-1:0] rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  side_t           side_q [RW];
  logic            vld_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [SUMW-1:0] rest_in;
    logic [REMW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    side_t           side_in;
    logic            vld_in;
    logic [REMW+1:0] cur, trial, diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign rest_in = sos_i.sum;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = sos_i.side;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rest_in = rest_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    always_comb begin
      cur   = {rem_in, rest_in[SUMW-1 -: 2]};
      trial = (REMW+2)'({root_in, 2'b01});
      diff  = cur - trial;
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rest_q[k] <= rest_in << 2;
        rem_q[k]  <= ge ? diff[REMW-1:0] : cur[REMW-1:0];
        root_q[k] <= {root_in[RW-2:0], ge};
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign vld_o       = vld_q[RW-1];
  assign root_o.root = root_q[RW-1];
  assign root_o.side = side_q[RW-1];

endmodule

/* rtl/tun_div.sv */
// ----------------------------------------------------------------------------
// tun_div - three parallel restoring dividers, rounded quotient m * 2^30 / r
// One setup stage, then one quotient bit per register stage.
// ----------------------------------------------------------------------------
module tun_div import tun_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  vld_i,
  input  root_t root_i,
  output logic  vld_o,
  output quo_t  quo_o
);

  typedef struct packed {
    logic [2:0][RW-1:0] rem;
    logic [2:0][QW-1:0] nlow;
    logic [2:0][QW-1:0] q;
    logic [RW-1:0]      r;
    logic [2:0]         neg;
    logic               deg;
  } dst_t;

  logic [NUMW-1:0] num [3];
  dst_t            set_d, set_q;
  logic            set_vld_q;
  dst_t            st_q  [QW];
  logic            vld_q [QW];

  // dividend with half the divisor added for rounding
  always_comb begin
    set_d.r   = root_i.root;
    set_d.neg = root_i.side.neg;
    set_d.deg = root_i.side.deg;
    for (int i = 0; i < 3; i++) begin
      num[i]         = {1'b0, root_i.side.m[i], FRAC'(0)} + NUMW'(root_i.root >> 1);
      set_d.rem[i]   = RW'(num[i][NUMW-1:QW]);
      set_d.nlow[i]  = num[i][QW-1:0];
      set_d.q[i]     = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) set_q <= set_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_vld_q <= 1'b0;
    end else if (adv_i) begin
      set_vld_q <= vld_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_st
    dst_t          in_s, nx;
    logic          vld_in;
    logic [RW:0]   cur [3];
    logic [RW:0]   diff [3];
    logic          ge [3];

    if (k == 0) begin : g_first
      assign in_s   = set_q;
      assign vld_in = set_vld_q;
    end else begin : g_next
      assign in_s   = st_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    always_comb begin
      nx = in_s;
      for (int i = 0; i < 3; i++) begin
        cur[i]     = {in_s.rem[i], in_s.nlow[i][QW-1]};
        diff[i]    = cur[i] - {1'b0, in_s.r};
        ge[i]      = (cur[i] >= {1'b0, in_s.r});
        nx.rem[i]  = ge[i] ? diff[i][RW-1:0] : cur[i][RW-1:0];
        nx.nlow[i] = in_s.nlow[i] << 1;
        nx.q[i]    = {in_s.q[i][QW-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) st_q[k] <= nx;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign vld_o     = vld_q[QW-1];
  assign quo_o.q   = st_q[QW-1].q;
  assign quo_o.neg = st_q[QW-1].neg;
  assign quo_o.deg = st_q[QW-1].deg;

endmodule

/* rtl/triangle_unit_normal.sv */
// ----------------------------------------------------------------------------
// triangle_unit_normal - unit face normal of a triangle, Q16.16 in, Q2.30 out
// Edge vectors, exact cross product, normalize by square root and divide.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: valid_i / stall_o with one triangle word on tri_i, three
//   vertices a, b, c. A word is taken at a clock edge with valid_i high and
//   stall_o low. Output channel: valid_o / stall_i with one normal word on
//   nrm_o; a word leaves at an edge with valid_o high and stall_i low.
//   Throughput: one word per cycle while stall_o is low, back to back, no gaps needed.
//   Path: a word passes 72 register stages, the first loaded at the
//   accepting edge: the 32 root stages and the 31 quotient stages (one bit
//   per stage), plus 7 cross product and scaling stages, the divide setup
//   stage and the output register.
//   Zero-area triangles give a zero normal with degenerate set.
//   Reset clears all valid bits; the block takes words right after.
//   Stall: a two-entry output buffer (output register plus skid) sits at
//   the end. When the receiver stalls, the skid fills, stall_o rises and the
//   whole pipeline holds in place until the skid drains. Nothing is lost or
//   repeated; stall_o comes straight from a register.
// ----------------------------------------------------------------------------
module triangle_unit_normal import tun_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  tri_in_t  tri_i,
  output logic     valid_o,
  input  logic     stall_i,
  output nrm_out_t nrm_o
);

  logic     adv;
  logic     crs_vld, sos_vld, root_vld, quo_vld;
  crs_t     crs;
  sos_t     sos;
  root_t    root;
  quo_t     quo;
  nrm_out_t res;
  nrm_out_t out_q, skid_q;
  logic     out_vld_q, skid_vld_q;
  logic     push, pop;

  // advance the whole pipeline while the skid has room
  assign adv     = !skid_vld_q;
  assign stall_o = skid_vld_q;

  tun_cross u_cross (
    .clk_i, .rst_ni, .adv_i(adv),
    .vld_i(valid_i), .tri_i,
    .vld_o(crs_vld), .crs_o(crs)
  );

  tun_norm u_norm (
    .clk_i, .rst_ni, .adv_i(adv),
    .vld_i(crs_vld), .crs_i(crs),
    .vld_o(sos_vld), .sos_o(sos)
  );

  tun_sqrt u_sqrt (
    .clk_i, .rst_ni, .adv_i(adv),
    .vld_i(sos_vld), .sos_i(sos),
    .vld_o(root_vld), .root_o(root)
  );

  tun_div u_div (
    .clk_i, .rst_ni, .adv_i(adv),
    .vld_i(root_vld), .root_i(root),
    .vld_o(quo_vld), .quo_o(quo)
  );

  // apply signs; force zero on a degenerate triangle
  always_comb begin
    res.degenerate = quo.deg;
    res.normal_x   = quo.deg ? '0 : quo.neg[0] ? -OW'(quo.q[0]) : OW'(quo.q[0]);
    res.normal_y   = quo.deg ? '0 : quo.neg[1] ? -OW'(quo.q[1]) : OW'(quo.q[1]);
    res.normal_z   = quo.deg ? '0 : quo.neg[2] ? -OW'(quo.q[2]) : OW'(quo.q[2]);
  end

  assign push = adv && quo_vld;
  assign pop  = out_vld_q && !stall_i;

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (!out_vld_q || pop) out_q  <= res;
      else                   skid_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) skid_vld_q <= 1'b0;
    end else if (push) begin
      if (out_vld_q && !pop) skid_vld_q <= 1'b1;
      out_vld_q <= 1'b1;
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  assign valid_o = out_vld_q;
  assign nrm_o   = out_q;

  // the skid only holds a word behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a word while output register is empty");

  // a drained skid leaves its word in the output register
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !stall_i) |=> (out_vld_q && !skid_vld_q))
    else $error("skid drain lost a word");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.degenerate) |->
      (out_q.normal_x == '0 && out_q.normal_y == '0 && out_q.normal_z == '0))
    else $error("degenerate normal is not zero");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |->
      (out_q.normal_x <= (OW'(1) <<< FRAC) && out_q.normal_x >= -(OW'(1) <<< FRAC) &&
       out_q.normal_y <= (OW'(1) <<< FRAC) && out_q.normal_y >= -(OW'(1) <<< FRAC) &&
       out_q.normal_z <= (OW'(1) <<< FRAC) && out_q.normal_z >= -(OW'(1) <<< FRAC)))
    else $error("normal component outside unit range");

endmodule
